FILE: rtl/smau_pkg.sv
// Package: widths, opcodes and pipeline beat type for the sign-magnitude arithmetic unit.
package smau_pkg;
    localparam int MAG_BITS  = 15;
    localparam int FRAC_BITS = 5;
    localparam int OPW       = 16;
    localparam int MW        = OPW;
    localparam int QW        = MW + FRAC_BITS;
    localparam int STAGES    = QW;

    typedef enum logic [2:0] {
        OP_ENCODE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]    op;
        logic [15:0]   direct_code;
        logic [15:0]   ones_code;
        logic [15:0]   twos_code;
        logic [16:0]   sum_value;
        logic          prod_sign;
        logic [29:0]   prod_mag;
        logic          q_sign;
        logic          dbz;
        logic [MW-1:0] divisor;
        logic [MW-1:0] rem;
        logic [QW-1:0] dividend;
        logic [QW-1:0] quot;
    } beat_t;
endpackage

FILE: rtl/smau_cell.sv
// One restoring-division cell: one quotient bit per stage, carries the rest of the beat.
module smau_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  smau_pkg::beat_t in_beat,
    output logic           out_valid,
    output smau_pkg::beat_t out_beat
);
    import smau_pkg::*;

    logic            valid_reg;
    beat_t           beat_reg;
    beat_t           beat_next;
    logic [MW:0]     trial;
    logic [MW:0]     diff;

    always_comb
    begin
        beat_next = in_beat;
        trial = {in_beat.rem, in_beat.dividend[QW-1]};
        diff  = trial - {1'b0, in_beat.divisor};
        beat_next.dividend = {in_beat.dividend[QW-2:0], 1'b0};
        if (!diff[MW])
        begin
            beat_next.rem  = diff[MW-1:0];
            beat_next.quot = {in_beat.quot[QW-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem  = trial[MW-1:0];
            beat_next.quot = {in_beat.quot[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;
endmodule

FILE: rtl/sign_magnitude_arith_unit.sv
// Top level: sign-magnitude arithmetic unit, front stage, cell chain and output stage.
// One beat per cycle is accepted; each result passes through one front stage, 21 division
// cells, then the output register. The chain stalls as a whole when the output register
// is full and not taken.
module sign_magnitude_arith_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,  // operand_a[15:0], operand_b[31:16]
    input  logic [2:0]   s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata   // direct_code, ones_code, twos_code, sum_value,
                                   // product_sign, product_magnitude, quotient_sign,
                                   // quotient_int, quotient_frac, divide_by_zero, pad
);
    import smau_pkg::*;

    logic               en;
    logic signed [16:0] a, b;
    logic [MW-1:0]      ma, mb;
    logic               sa, sb;
    logic [MAG_BITS-1:0] m;
    logic [15:0]        dir, ones;
    beat_t              front_next;
    logic               v [0:STAGES];
    beat_t              bt [0:STAGES];
    logic               out_valid_reg;
    logic [119:0]       out_data_reg;
    logic [119:0]       out_data_next;
    beat_t              last;
    logic               is_div;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        a  = {s_tdata[15], s_tdata[15:0]};
        b  = {s_tdata[31], s_tdata[31:16]};
        sa = a[16];
        sb = b[16];
        ma = sa ? MW'(-a) : a[MW-1:0];
        mb = sb ? MW'(-b) : b[MW-1:0];
        m  = ma[MAG_BITS-1:0];
        dir  = {sa, m};
        ones = sa ? {1'b1, ~m} : dir;
        front_next = '0;
        front_next.op = s_tuser;
        front_next.divisor  = mb;
        front_next.dividend = {ma, {FRAC_BITS{1'b0}}};
        front_next.q_sign   = sa ^ sb;
        front_next.dbz      = (mb == '0);
        case (s_tuser)
            OP_ENCODE:
            begin
                front_next.direct_code = dir;
                front_next.ones_code   = ones;
                front_next.twos_code   = sa ? ones + 16'd1 : dir;
            end
            OP_ADD:  front_next.sum_value = a + b;
            OP_SUB:  front_next.sum_value = a - b;
            OP_MUL:
            begin
                front_next.prod_sign = sa ^ sb;
                front_next.prod_mag  = 30'(32'(ma) * 32'(mb));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v[0] <= 1'b0;
        else if (en)
            v[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            bt[0] <= front_next;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        smau_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[i]),
            .in_beat   (bt[i]),
            .out_valid (v[i+1]),
            .out_beat  (bt[i+1])
        );
    end

    always_comb
    begin
        last   = bt[STAGES];
        is_div = (last.op == OP_DIV) && !last.dbz;
        out_data_next = '0;
        out_data_next[15:0]    = last.direct_code;
        out_data_next[31:16]   = last.ones_code;
        out_data_next[47:32]   = last.twos_code;
        out_data_next[64:48]   = last.sum_value;
        out_data_next[65]      = last.prod_sign;
        out_data_next[95:66]   = last.prod_mag;
        out_data_next[96]      = is_div & last.q_sign;
        out_data_next[111:97]  = is_div ? last.quot[FRAC_BITS+14:FRAC_BITS] : 15'd0;
        out_data_next[116:112] = is_div ? last.quot[FRAC_BITS-1:0] : 5'd0;
        out_data_next[117]     = (last.op == OP_DIV) && last.dbz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v[STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end
endmodule

FILE: rtl/smau_checker.sv
// Port checker for the sign-magnitude arithmetic unit, bound to the top level.
module smau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[117] && (m_tdata[116:96] != 21'd0)))
        else $error("quotient with zero divisor");
    a_enc_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !((m_tdata[47:0] != 48'd0) && (m_tdata[64:48] != 17'd0)))
        else $error("encode and sum both set");
endmodule

bind sign_magnitude_arith_unit smau_checker u_smau_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
